>>> rtl/assert_macros.svh
// Assertion macros for the checker module of the cave automaton block.
// No dependencies; included by files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CAG_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cave automaton check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CAG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cave automaton check failed");

`endif

>>> rtl/cag_pkg.sv
// Package for the cave automaton generation step: payload and register types,
// register map codes and default sizes. No dependencies.
`timescale 1ns / 1ps

package cag_pkg;

    localparam int DEF_MAX_WIDTH  = 128;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    localparam int GRID_WIDTH_W  = 8;
    localparam int GRID_HEIGHT_W = 11;
    localparam int RULE_W        = 4;

    // Codes of the action field.
    localparam logic ACT_CELL  = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    typedef enum logic [2:0] {
        REG_GRID_WIDTH   = 3'd0,
        REG_GRID_HEIGHT  = 3'd1,
        REG_DEATH_LIMIT  = 3'd2,
        REG_BIRTH_COUNT  = 3'd3,
        REG_FORCE_BORDER = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic action;
        logic cell_open;
    } cell_item_t;

    typedef struct packed {
        logic next_open;
        logic frame_end;
    } result_item_t;

    typedef struct packed {
        logic [GRID_WIDTH_W-1:0]  grid_width;
        logic [GRID_HEIGHT_W-1:0] grid_height;
        logic [RULE_W-1:0]        death_limit;
        logic [RULE_W-1:0]        birth_count;
        logic                     force_border;
    } cfg_regs_t;

    localparam cfg_regs_t CFG_RESET = '{
        grid_width:   GRID_WIDTH_W'(80),
        grid_height:  GRID_HEIGHT_W'(24),
        death_limit:  RULE_W'(3),
        birth_count:  RULE_W'(4),
        force_border: 1'b0
    };

    // One column of both line stores: the row two above and the row above.
    typedef struct packed {
        logic middle;
        logic upper;
    } row_pair_t;

    localparam row_pair_t ROW_PAIR_OPEN = '{middle: 1'b1, upper: 1'b1};

    localparam logic [8:0] WINDOW_OPEN = 9'h1FF;

endpackage

>>> rtl/cag_cfg.sv
// APB register file of the cave automaton block: grid size and rule registers.
// Depends on cag_pkg.
`timescale 1ns / 1ps

module cag_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cag_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [cag_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [cag_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    output cag_pkg::cfg_regs_t             cfg
);
    import cag_pkg::*;

    cfg_regs_t  cfg_reg;
    cfg_regs_t  cfg_next;
    reg_index_t index;
    logic       wr_en;

    assign pready = 1'b1;
    assign index  = reg_index_t'(paddr[CFG_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (index)
                REG_GRID_WIDTH:   cfg_next.grid_width   = pwdata[GRID_WIDTH_W-1:0];
                REG_GRID_HEIGHT:  cfg_next.grid_height  = pwdata[GRID_HEIGHT_W-1:0];
                REG_DEATH_LIMIT:  cfg_next.death_limit  = pwdata[RULE_W-1:0];
                REG_BIRTH_COUNT:  cfg_next.birth_count  = pwdata[RULE_W-1:0];
                REG_FORCE_BORDER: cfg_next.force_border = pwdata[0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            REG_GRID_WIDTH:   prdata = CFG_DATA_W'(cfg_reg.grid_width);
            REG_GRID_HEIGHT:  prdata = CFG_DATA_W'(cfg_reg.grid_height);
            REG_DEATH_LIMIT:  prdata = CFG_DATA_W'(cfg_reg.death_limit);
            REG_BIRTH_COUNT:  prdata = CFG_DATA_W'(cfg_reg.birth_count);
            REG_FORCE_BORDER: prdata = CFG_DATA_W'(cfg_reg.force_border);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> rtl/cag_row_mem.sv
// Line store memory: one entry per column holding the two previous rows.
// Synchronous read, data in the cycle after the address, write forwarding. Depends on cag_pkg.
`timescale 1ns / 1ps

module cag_row_mem #(
    parameter int DEPTH = cag_pkg::DEF_MAX_WIDTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [AW-1:0]      wr_addr,
    input  cag_pkg::row_pair_t wr_data,
    input  logic [AW-1:0]      rd_addr,
    output cag_pkg::row_pair_t rd_data
);
    import cag_pkg::*;

    row_pair_t        row_mem_reg [DEPTH];
    row_pair_t        rd_raw_reg;
    row_pair_t        fwd_data_reg;
    logic             fwd_reg;
    logic             vld_reg;
    logic [DEPTH-1:0] valid_reg;
    logic [DEPTH-1:0] valid_next;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            row_mem_reg[wr_addr] <= wr_data;
        end
        rd_raw_reg   <= row_mem_reg[rd_addr];
        fwd_data_reg <= wr_data;
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (wr_en)
        begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    // Entries never written since reset read as open floor.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            fwd_reg   <= 1'b0;
            vld_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            fwd_reg   <= wr_en && (wr_addr == rd_addr);
            vld_reg   <= valid_reg[rd_addr];
        end
    end

    assign rd_data = fwd_reg ? fwd_data_reg : (vld_reg ? rd_raw_reg : ROW_PAIR_OPEN);

endmodule

>>> rtl/cag_core.sv
// Raster engine of the cave automaton: column and row counters, 3x3 window,
// neighbour count and cell rule. Reads and rewrites the line store each cell.
// Depends on cag_pkg.
`timescale 1ns / 1ps

module cag_core #(
    parameter int MAX_WIDTH  = cag_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = cag_pkg::DEF_MAX_HEIGHT,
    parameter int CW         = $clog2(MAX_WIDTH)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cag_pkg::cfg_regs_t    cfg,
    input  logic                  cell_valid,
    input  cag_pkg::cell_item_t   cell_item,
    input  logic                  buf_ready,
    output logic                  push_valid,
    output cag_pkg::result_item_t push_item,
    output logic                  mem_wr_en,
    output logic [CW-1:0]         mem_wr_addr,
    output cag_pkg::row_pair_t    mem_wr_data,
    output logic [CW-1:0]         mem_rd_addr,
    input  cag_pkg::row_pair_t    mem_rd_data
);
    import cag_pkg::*;

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 2) + 1;

    function automatic logic [3:0] popcount8(input logic [7:0] bits);
        logic [3:0] sum;
        sum = '0;
        for (int i = 0; i < 8; i++)
        begin
            sum = sum + 4'(bits[i]);
        end
        return sum;
    endfunction

    logic [CW-1:0] in_col_reg,  in_col_next;
    logic [RW-1:0] in_row_reg,  in_row_next;
    logic [CW-1:0] out_col_reg, out_col_next;
    logic [RW-1:0] out_row_reg, out_row_next;
    logic [8:0]    window_reg,  window_next;

    logic [31:0]   gw32, gh32;
    logic [WW-1:0] w_used;
    logic [HW-1:0] h_used;
    logic [RW-1:0] h_ext;
    logic          draining, do_adv, emit, v, col0;
    logic [WW-1:0] c_inc, qc_inc;
    logic [RW-1:0] r_inc, qr_inc;
    logic [2:0]    new_col;
    logic [8:0]    win_shift;
    logic [2:0]    lcol, ccol, rcol;
    logic          up_ok, down_ok, left_ok, right_ok, on_border;
    logic [7:0]    nb;
    logic [3:0]    cnt;
    logic          res, fend;

    // Register values outside the legal range are clamped.
    assign gw32   = 32'(cfg.grid_width);
    assign gh32   = 32'(cfg.grid_height);
    assign w_used = (gw32 < 32'd3) ? WW'(3)
                  : (gw32 > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(gw32);
    assign h_used = (gh32 < 32'd3) ? HW'(3)
                  : (gh32 > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(gh32);
    assign h_ext  = RW'(h_used);

    assign draining = in_row_reg >= h_ext;
    assign do_adv   = cell_valid && buf_ready && (draining || cell_item.action == ACT_CELL);
    assign v        = draining ? 1'b1 : cell_item.cell_open;
    assign emit     = ((in_row_reg != '0) && (in_col_reg != '0)) || (in_row_reg > RW'(1));

    assign c_inc  = WW'(in_col_reg) + WW'(1);
    assign qc_inc = WW'(out_col_reg) + WW'(1);
    assign r_inc  = in_row_reg + RW'(1);
    assign qr_inc = out_row_reg + RW'(1);

    assign new_col   = {v, mem_rd_data.middle, mem_rd_data.upper};
    assign win_shift = {new_col, window_reg[8:3]};
    assign col0      = in_col_reg == '0;

    // At column zero the output cell sits at the right edge of the previous
    // row, so the window before the shift is used and has no right column.
    assign lcol = col0 ? window_reg[5:3] : win_shift[2:0];
    assign ccol = col0 ? window_reg[8:6] : win_shift[5:3];
    assign rcol = win_shift[8:6];

    assign up_ok    = out_row_reg != '0;
    assign down_ok  = qr_inc < h_ext;
    assign left_ok  = out_col_reg != '0;
    assign right_ok = !col0 && (qc_inc < w_used);

    // Neighbours off the map count as open.
    assign nb[0] = lcol[0] | ~(up_ok & left_ok);
    assign nb[1] = lcol[1] | ~left_ok;
    assign nb[2] = lcol[2] | ~(down_ok & left_ok);
    assign nb[3] = rcol[0] | ~(up_ok & right_ok);
    assign nb[4] = rcol[1] | ~right_ok;
    assign nb[5] = rcol[2] | ~(down_ok & right_ok);
    assign nb[6] = ccol[0] | ~up_ok;
    assign nb[7] = ccol[2] | ~down_ok;
    assign cnt   = popcount8(nb);

    assign on_border = !up_ok || !down_ok || !left_ok || (qc_inc >= w_used);

    always_comb
    begin
        if (ccol[1])
        begin
            res = cnt >= cfg.death_limit;
        end
        else
        begin
            res = cnt == cfg.birth_count;
        end
        if (cfg.force_border && on_border)
        begin
            res = 1'b0;
        end
    end

    assign fend = (qr_inc >= h_ext) && (qc_inc >= w_used);

    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        window_next  = window_reg;
        if (do_adv)
        begin
            window_next = win_shift;
            if (c_inc >= w_used)
            begin
                in_col_next = '0;
                in_row_next = r_inc;
            end
            else
            begin
                in_col_next = CW'(c_inc);
            end
            if (emit)
            begin
                priority if (fend)
                begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end
                else if (qc_inc >= w_used)
                begin
                    out_col_next = '0;
                    out_row_next = qr_inc;
                end
                else
                begin
                    out_col_next = CW'(qc_inc);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            window_reg  <= WINDOW_OPEN;
        end
        else
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            window_reg  <= window_next;
        end
    end

    // The read address follows the column of the next cell, so its data is
    // waiting when that cell arrives.
    assign mem_rd_addr = in_col_next;
    assign mem_wr_en   = do_adv;
    assign mem_wr_addr = in_col_reg;
    assign mem_wr_data = '{middle: v, upper: mem_rd_data.middle};

    assign push_valid          = do_adv && emit;
    assign push_item.next_open = res;
    assign push_item.frame_end = fend;

endmodule

>>> rtl/cag_out_buf.sv
// Output register with a skid stage for result transactions.
// Depends on cag_pkg.
`timescale 1ns / 1ps

module cag_out_buf (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_valid,
    input  cag_pkg::result_item_t push_item,
    output logic                  push_ready,
    output logic                  result_valid,
    input  logic                  result_ready,
    output cag_pkg::result_item_t result_item
);
    import cag_pkg::*;

    logic         main_valid_reg, main_valid_next;
    logic         skid_valid_reg, skid_valid_next;
    result_item_t main_data_reg,  main_data_next;
    result_item_t skid_data_reg,  skid_data_next;
    logic         pop;

    assign pop          = main_valid_reg && result_ready;
    assign push_ready   = !skid_valid_reg;
    assign result_valid = main_valid_reg;
    assign result_item  = main_data_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push_valid)
        begin
            if (!main_valid_reg || pop)
            begin
                main_data_next  = push_item;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = push_item;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

endmodule

>>> rtl/cave_automaton_generation_step.sv
// Cave automaton generation step: one old-generation cell in per cycle, one cell
// of the next generation out per cycle when not stalled, one row plus one cell
// behind the input. Throughput: one cell per cycle while the output buffer has
// room, set by the single read and write of the line store.
// Reset (rst_n, asynchronous): counters cleared, window and line store read as open
// floor, registers at their defaults; no clearing pass, a cell is taken at once.
`timescale 1ns / 1ps

module cave_automaton_generation_step #(
    parameter int MAX_WIDTH  = cag_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = cag_pkg::DEF_MAX_HEIGHT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cag_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [cag_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [cag_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    input  logic                           cell_valid,
    output logic                           cell_ready,
    input  cag_pkg::cell_item_t            cell_item,
    output logic                           result_valid,
    input  logic                           result_ready,
    output cag_pkg::result_item_t          result_item
);
    import cag_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    cfg_regs_t    cfg;
    logic         buf_ready;
    logic         push_valid;
    result_item_t push_item;
    logic         mem_wr_en;
    logic [CW-1:0] mem_wr_addr;
    logic [CW-1:0] mem_rd_addr;
    row_pair_t    mem_wr_data;
    row_pair_t    mem_rd_data;

    assign cell_ready = buf_ready;

    cag_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cag_row_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_row_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    cag_core #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .CW         (CW)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .cell_valid  (cell_valid),
        .cell_item   (cell_item),
        .buf_ready   (buf_ready),
        .push_valid  (push_valid),
        .push_item   (push_item),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    cag_out_buf u_out_buf (
        .clk          (clk),
        .rst_n        (rst_n),
        .push_valid   (push_valid),
        .push_item    (push_item),
        .push_ready   (buf_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item)
    );

endmodule

>>> rtl/cag_checker.sv
// Port-level checks of the cave automaton block, bound to its top level.
// Depends on cag_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cag_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  cell_valid,
    input logic                  cell_ready,
    input logic                  result_valid,
    input logic                  result_ready,
    input cag_pkg::result_item_t result_item
);
    import cag_pkg::*;

    // A stalled result stays offered and unchanged.
    `CAG_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && !result_ready, result_valid)
    `CAG_ASSERT_NEXT(a_result_stable, clk, rst_n, result_valid && !result_ready, $stable(result_item))

    // A new result only follows an accepted cell transaction.
    `CAG_ASSERT_SAME(a_result_cause, clk, rst_n, $rose(result_valid), $past(cell_valid && cell_ready))

    // The input side stalls only when both output stages are full.
    `CAG_ASSERT_SAME(a_stall_full, clk, rst_n, !cell_ready, result_valid)

endmodule

bind cave_automaton_generation_step cag_checker u_cag_checker (.*);

>>> verif/tb_cave_automaton_generation_step.sv
// Self-checking testbench for the cave automaton generation step: streams cave frames
// through the block, predicts every next-generation cell and checks it on the way out.
// Depends on cag_pkg and cave_automaton_generation_step.
`timescale 1ns / 1ps

module tb_cave_automaton_generation_step;

    import cag_pkg::*;

    localparam int LINE_CELLS     = DEF_MAX_WIDTH;
    localparam int ROWS_MAX       = DEF_MAX_HEIGHT;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PRESSURE_HOLD  = 400;
    localparam int REPORT_LIMIT   = 20;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  cell_valid;
    logic                  cell_ready;
    cell_item_t            cell_item;
    logic                  result_valid;
    logic                  result_ready;
    result_item_t          result_item;

    // Register shadow used by the predictor.
    logic [GRID_WIDTH_W-1:0]  size_w_reg;
    logic [GRID_HEIGHT_W-1:0] size_h_reg;
    logic [RULE_W-1:0]        rule_death;
    logic [RULE_W-1:0]        rule_birth;
    logic                     border_wall;

    // Predictor state: two line buffers, the 3x3 neighborhood and the raster positions.
    logic        older_line [LINE_CELLS];
    logic        newer_line [LINE_CELLS];
    logic [8:0]  nbhd;
    int unsigned feed_col;
    int unsigned feed_row;
    int unsigned emit_col;
    int unsigned emit_row;

    result_item_t next_gen_q[$];
    result_item_t want;

    int error_count;
    int reported;
    int results_checked;
    int frames_seen;
    int cell_items;
    int flush_items;
    int ignored_items;
    int stall_cycles;
    int tx_idle_pct;
    int rx_idle_pct;
    int rx_hold_left;

    cave_automaton_generation_step i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .cell_valid   (cell_valid),
        .cell_ready   (cell_ready),
        .cell_item    (cell_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic int unsigned eff_width();
        int unsigned w;
        w = size_w_reg;
        if (w < 3) w = 3;
        if (w > LINE_CELLS) w = LINE_CELLS;
        return w;
    endfunction

    function automatic int unsigned eff_height();
        int unsigned h;
        h = size_h_reg;
        if (h < 3) h = 3;
        if (h > ROWS_MAX) h = ROWS_MAX;
        return h;
    endfunction

    // Applies the birth and death rules to the cell at the current output position.
    // Neighbors off the map count as open floor.
    function automatic logic rule_cell(input logic [8:0] win, input int lc, input int cc,
                                       input int rc, input bit right_in, input int unsigned w,
                                       input int unsigned h);
        int unsigned cnt;
        int          r;
        bit          up_ok;
        bit          down_ok;
        bit          left_ok;
        bit          right_ok;
        bit          row_ok;
        logic        res;
        up_ok    = emit_row != 0;
        down_ok  = emit_row + 1 < h;
        left_ok  = emit_col != 0;
        right_ok = right_in && (emit_col + 1 < w);
        cnt = 0;
        for (r = 0; r < 3; r++)
        begin
            row_ok = (r == 0) ? up_ok : ((r == 2) ? down_ok : 1'b1);
            cnt += (row_ok && left_ok) ? win[lc * 3 + r] : 1;
            cnt += (row_ok && right_ok) ? win[rc * 3 + r] : 1;
            if (r != 1)
                cnt += row_ok ? win[cc * 3 + r] : 1;
        end
        if (win[cc * 3 + 1])
            res = (cnt < rule_death) ? 1'b0 : 1'b1;
        else
            res = (cnt == rule_birth) ? 1'b1 : 1'b0;
        if (border_wall && (emit_row == 0 || emit_row + 1 >= h || emit_col == 0
                            || emit_col + 1 >= w))
            res = 1'b0;
        return res;
    endfunction

    task automatic reset_automaton();
        size_w_reg  = CFG_RESET.grid_width;
        size_h_reg  = CFG_RESET.grid_height;
        rule_death  = CFG_RESET.death_limit;
        rule_birth  = CFG_RESET.birth_count;
        border_wall = CFG_RESET.force_border;
        for (int i = 0; i < LINE_CELLS; i++)
        begin
            older_line[i] = 1'b1;
            newer_line[i] = 1'b1;
        end
        nbhd     = WINDOW_OPEN;
        feed_col = 0;
        feed_row = 0;
        emit_col = 0;
        emit_row = 0;
    endtask

    // Shifts one cell into the window and queues the output cell it completes, if any.
    task automatic advance_window(input logic v);
        int unsigned  w;
        int unsigned  h;
        int unsigned  c;
        int unsigned  r;
        bit           emit;
        logic [2:0]   newcol;
        logic         res;
        result_item_t out;
        w      = eff_width();
        h      = eff_height();
        c      = feed_col;
        r      = feed_row;
        emit   = (r >= 1 && c >= 1) || r >= 2;
        newcol = {v, newer_line[c], older_line[c]};
        res    = 1'b0;
        older_line[c] = newer_line[c];
        newer_line[c] = v;
        if (c == 0)
        begin
            // The window still holds the previous row's last columns.
            if (emit) res = rule_cell(nbhd, 1, 2, 2, 1'b0, w, h);
            nbhd = {newcol, nbhd[8:3]};
        end
        else
        begin
            nbhd = {newcol, nbhd[8:3]};
            if (emit) res = rule_cell(nbhd, 0, 1, 2, 1'b1, w, h);
        end
        if (c + 1 >= w)
        begin
            feed_col = 0;
            feed_row = r + 1;
        end
        else
            feed_col = c + 1;
        if (emit)
        begin
            out.next_open = res;
            out.frame_end = 1'b0;
            if (emit_row + 1 >= h && emit_col + 1 >= w)
            begin
                out.frame_end = 1'b1;
                feed_col = 0;
                feed_row = 0;
                emit_col = 0;
                emit_row = 0;
            end
            else if (emit_col + 1 >= w)
            begin
                emit_col = 0;
                emit_row++;
            end
            else
                emit_col++;
            next_gen_q.push_back(out);
        end
    endtask

    task automatic step_automaton(input cell_item_t item);
        if (feed_row >= eff_height())
        begin
            // While draining, any transaction releases one pending cell.
            advance_window(1'b1);
            flush_items++;
        end
        else if (item.action == ACT_CELL)
        begin
            advance_window(item.cell_open);
            cell_items++;
        end
        else
            ignored_items++;
    endtask

    // Entered and left at a falling edge; valid stays high between back-to-back items.
    task automatic send_item(input logic act, input logic open_bit);
        cell_item_t item;
        item.action    = act;
        item.cell_open = open_bit;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            cell_valid <= 1'b0;
            @(negedge clk);
        end
        cell_valid <= 1'b1;
        cell_item  <= item;
        @(posedge clk);
        while (!cell_ready) @(posedge clk);
        step_automaton(item);
        @(negedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(4 * int'(idx));
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        case (idx)
            REG_GRID_WIDTH:   size_w_reg  = value[GRID_WIDTH_W-1:0];
            REG_GRID_HEIGHT:  size_h_reg  = value[GRID_HEIGHT_W-1:0];
            REG_DEATH_LIMIT:  rule_death  = value[RULE_W-1:0];
            REG_BIRTH_COUNT:  rule_birth  = value[RULE_W-1:0];
            REG_FORCE_BORDER: border_wall = value[0];
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Waits for every predicted cell, then lets an ignored flush settle.
    task automatic wait_drained();
        cell_valid <= 1'b0;
        while (next_gen_q.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic drain_frame(input int cell_pct);
        while (feed_row >= eff_height())
            send_item(($urandom_range(0, 99) < cell_pct) ? ACT_CELL : ACT_FLUSH,
                      1'($urandom_range(0, 1)));
    endtask

    task automatic play_frame(input int open_pct, input int noise_pct);
        int unsigned total;
        total = eff_width() * eff_height();
        for (int unsigned i = 0; i < total; i++)
        begin
            if ($urandom_range(0, 99) < noise_pct)
                send_item(ACT_FLUSH, 1'($urandom_range(0, 1)));
            send_item(ACT_CELL, $urandom_range(0, 99) < open_pct);
        end
        drain_frame(20);
        wait_drained();
    endtask

    task automatic test_idle_flush();
        send_item(ACT_FLUSH, 1'b0);
        send_item(ACT_FLUSH, 1'b1);
        wait_drained();
    endtask

    task automatic test_small_frames();
        // Sizes below the minimum clamp to 3x3; all-open field with border forcing.
        write_reg(REG_GRID_WIDTH, 32'd0);
        write_reg(REG_GRID_HEIGHT, 32'd0);
        write_reg(REG_DEATH_LIMIT, 32'd0);
        write_reg(REG_BIRTH_COUNT, 32'd8);
        write_reg(REG_FORCE_BORDER, 32'd1);
        for (int i = 0; i < 9; i++)
        begin
            send_item(ACT_CELL, 1'b1);
            if (i == 4) send_item(ACT_FLUSH, 1'b1);
        end
        send_item(ACT_CELL, 1'b0);
        drain_frame(0);
        wait_drained();
        // Out-of-range rules: every open cell dies and no wall ever opens.
        write_reg(REG_DEATH_LIMIT, 32'd15);
        write_reg(REG_BIRTH_COUNT, 32'd15);
        write_reg(REG_FORCE_BORDER, 32'd0);
        for (int i = 0; i < 9; i++)
            send_item(ACT_CELL, 1'(i % 2));
        drain_frame(50);
        wait_drained();
    endtask

    task automatic test_size_extremes();
        write_reg(REG_DEATH_LIMIT, 32'd3);
        write_reg(REG_BIRTH_COUNT, 32'd5);
        write_reg(REG_GRID_WIDTH, 32'd255);
        write_reg(REG_GRID_HEIGHT, 32'd3);
        play_frame(50, 2);
        write_reg(REG_GRID_WIDTH, 32'd3);
        write_reg(REG_GRID_HEIGHT, 32'd20);
        play_frame(55, 0);
    endtask

    task automatic test_backpressure();
        write_reg(REG_GRID_WIDTH, 32'd10);
        write_reg(REG_GRID_HEIGHT, 32'd5);
        @(posedge clk);
        rx_hold_left = PRESSURE_HOLD;
        @(negedge clk);
        play_frame(50, 0);
    endtask

    task automatic test_random_frames(input int target);
        int start;
        int roll;
        start = cell_items;
        while (cell_items - start < target)
        begin
            roll = $urandom_range(0, 99);
            write_reg(REG_GRID_WIDTH, (roll < 8) ? $urandom_range(0, 2)
                      : (roll < 90) ? $urandom_range(3, 12) : $urandom_range(13, 48));
            roll = $urandom_range(0, 99);
            write_reg(REG_GRID_HEIGHT, (roll < 10) ? $urandom_range(0, 2) : $urandom_range(3, 7));
            roll = $urandom_range(0, 99);
            write_reg(REG_DEATH_LIMIT, (roll < 80) ? $urandom_range(2, 6) : $urandom_range(0, 15));
            roll = $urandom_range(0, 99);
            write_reg(REG_BIRTH_COUNT, (roll < 75) ? $urandom_range(2, 6) : $urandom_range(0, 15));
            write_reg(REG_FORCE_BORDER, $urandom_range(0, 1));
            play_frame($urandom_range(25, 75), 5);
        end
    endtask

    // Result side: random stalls, plus a long hold-off when a test asks for one.
    always @(negedge clk)
    begin
        if (rx_hold_left > 0)
        begin
            result_ready <= 1'b0;
            rx_hold_left--;
        end
        else
            result_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (next_gen_q.size() == 0)
            begin
                error_count++;
                reported++;
                if (reported <= REPORT_LIMIT)
                    $display("%0t: unexpected transaction, expected none, actual %b/%b", $time,
                             result_item.next_open, result_item.frame_end);
            end
            else
            begin
                want = next_gen_q.pop_front();
                results_checked++;
                if (want.frame_end) frames_seen++;
                if (result_item.next_open !== want.next_open
                    || result_item.frame_end !== want.frame_end)
                begin
                    error_count++;
                    reported++;
                    if (reported <= REPORT_LIMIT)
                        $display("%0t: next_open/frame_end mismatch, expected %b/%b, actual %b/%b",
                                 $time, want.next_open, want.frame_end,
                                 result_item.next_open, result_item.frame_end);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cell_valid && cell_ready) || (result_valid && result_ready) || (psel && penable))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, stall_cycles);
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        cell_valid   = 1'b0;
        cell_item    = '0;
        result_ready = 1'b0;
        error_count     = 0;
        reported        = 0;
        results_checked = 0;
        frames_seen     = 0;
        cell_items      = 0;
        flush_items     = 0;
        ignored_items   = 0;
        stall_cycles    = 0;
        rx_hold_left    = 0;
        tx_idle_pct     = 6;
        rx_idle_pct     = 67;
        reset_automaton();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_idle_flush();
        test_small_frames();
        test_random_frames(50);

        tx_idle_pct = 67;
        rx_idle_pct = 6;
        test_random_frames(50);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_size_extremes();
        test_backpressure();
        test_random_frames(50);

        wait_drained();
        repeat (8) @(negedge clk);
        if (next_gen_q.size() != 0)
        begin
            error_count++;
            $display("%0t: %0d expected cells never arrived", $time, next_gen_q.size());
        end
        $display("Covered %0d cells, %0d drain transactions and %0d ignored flushes; %0d cells",
                 cell_items, flush_items, ignored_items, results_checked);
        $display("checked over %0d frames, with clamped sizes, extreme rules and border forcing.",
                 frames_seen);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
